// ----- hw/rtl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Types, constants and helper functions for the script token scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stc_pkg;

   localparam int OFF_W = 24;
   localparam int LINE_W = 24;
   localparam int KW_COUNT = 17;
   localparam int MAX_TOKENS = 3;

   localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
   localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'd0,
      MODE_SLASH    = 4'd1,
      MODE_COMMENT  = 4'd2,
      MODE_IDENT    = 4'd3,
      MODE_NUMBER   = 4'd4,
      MODE_NUMDOT   = 4'd5,
      MODE_FRACTION = 4'd6,
      MODE_STRING   = 4'd7,
      MODE_OPERATOR = 4'd8
   } scan_mode_type;

   localparam logic [5:0] K_LPAREN     = 6'd0;
   localparam logic [5:0] K_RPAREN     = 6'd1;
   localparam logic [5:0] K_LBRACE     = 6'd2;
   localparam logic [5:0] K_RBRACE     = 6'd3;
   localparam logic [5:0] K_LBRACKET   = 6'd4;
   localparam logic [5:0] K_RBRACKET   = 6'd5;
   localparam logic [5:0] K_SEMICOLON  = 6'd6;
   localparam logic [5:0] K_COMMA      = 6'd7;
   localparam logic [5:0] K_DOT        = 6'd8;
   localparam logic [5:0] K_MINUS      = 6'd9;
   localparam logic [5:0] K_PLUS       = 6'd10;
   localparam logic [5:0] K_SLASH      = 6'd11;
   localparam logic [5:0] K_STAR       = 6'd12;
   localparam logic [5:0] K_OP_BASE    = 6'd13;
   localparam logic [5:0] K_IDENT      = 6'd21;
   localparam logic [5:0] K_STRING     = 6'd22;
   localparam logic [5:0] K_NUMBER     = 6'd23;
   localparam logic [5:0] K_KEYWORD    = 6'd24;
   localparam logic [5:0] K_ERR_CHAR   = 6'd41;
   localparam logic [5:0] K_ERR_STRING = 6'd42;
   localparam logic [5:0] K_EOF        = 6'd43;

   localparam logic [1:0] OP_BANG    = 2'd0;
   localparam logic [1:0] OP_EQUAL   = 2'd1;
   localparam logic [1:0] OP_GREATER = 2'd2;
   localparam logic [1:0] OP_LESS    = 2'd3;

   // keyword text, first character in the low byte
   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      48'("dna"), 48'("ssalc"), 48'("tsnoc"), 48'("esle"), 48'("eslaf"),
      48'("rof"), 48'("nuf"), 48'("fi"), 48'("lin"), 48'("ro"),
      48'("tnirp"), 48'("nruter"), 48'("repus"), 48'("siht"), 48'("eurt"),
      48'("rav"), 48'("elihw")
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2,
      3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
   };

   typedef struct packed {
      logic [5:0]        kind;
      logic [OFF_W-1:0]  offset;
      logic [OFF_W-1:0]  length;
      logic [LINE_W-1:0] line;
   } token_type;

   typedef struct packed {
      token_type [MAX_TOKENS-1:0] tok;
      logic [1:0]                 count;
   } tok_bundle_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] ident_kind(input logic [47:0] prefix,
                                             input logic [OFF_W-1:0] len);
      logic [5:0]  kind;
      logic [47:0] mask;
      kind = K_IDENT;
      if (len >= OFF_W'(2) && len <= OFF_W'(6)) begin
         for (int k = KW_COUNT - 1; k >= 0; k--) begin
            mask = ~(48'hFFFF_FFFF_FFFF << (8 * KW_LEN[k]));
            if (len[2:0] == KW_LEN[k] && (prefix & mask) == KW_TEXT[k])
               kind = K_KEYWORD + 6'(k);
         end
      end
      return kind;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/stc_if.sv -----
// ----------------------------------------------------------------------------
// stc_req_if / stc_rsp_if
// Valid/ready channels for source bytes and scanned tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface stc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   modport source (output valid, output source_byte, input ready);
   modport sink (input valid, input source_byte, output ready);
endinterface

interface stc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [5:0]                 token_kind;
   logic [stc_pkg::OFF_W-1:0]  token_offset;
   logic [stc_pkg::OFF_W-1:0]  token_length;
   logic [stc_pkg::LINE_W-1:0] token_line;
   logic                       last_in_run;
   modport source (output valid, output token_kind, output token_offset,
                   output token_length, output token_line, output last_in_run,
                   input ready);
   modport sink (input valid, input token_kind, input token_offset,
                 input token_length, input token_line, input last_in_run,
                 output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/stc_step.sv -----
// ----------------------------------------------------------------------------
// stc_step
// Scan state registers and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stc_step (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              source_byte,
   output stc_pkg::tok_bundle_type      bundle
);
   import stc_pkg::*;

   scan_mode_type     mode_ff, mode_in;
   logic [1:0]        pend_ff, pend_in;
   logic [OFF_W-1:0]  start_ff, start_in;
   logic [OFF_W-1:0]  read_ff, read_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [47:0]       prefix_ff, prefix_in;

   logic [OFF_W-1:0]  p_inc;
   logic [OFF_W-1:0]  len_p;
   logic [OFF_W-1:0]  len_inc;
   logic [LINE_W-1:0] line_up;
   logic [5:0]        op_kind;
   logic              done;
   logic [1:0]        cnt;
   token_type [MAX_TOKENS-1:0] tok;

   function automatic token_type mk(input logic [5:0] kind,
                                    input logic [OFF_W-1:0] off,
                                    input logic [OFF_W-1:0] len,
                                    input logic [LINE_W-1:0] line);
      token_type t;
      t.kind = kind;
      t.offset = off;
      t.length = len;
      t.line = line;
      return t;
   endfunction

   assign p_inc   = (read_ff == OFF_MAX) ? read_ff : read_ff + OFF_W'(1);
   assign len_p   = (read_ff >= start_ff) ? read_ff - start_ff : '0;
   assign len_inc = (p_inc >= start_ff) ? p_inc - start_ff : '0;
   assign line_up = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_W'(1);
   assign op_kind = K_OP_BASE + {3'd0, pend_ff, 1'b0};

   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      start_in = start_ff;
      read_in = read_ff;
      line_in = line_ff;
      prefix_in = prefix_ff;
      done = 1'b0;
      cnt = 2'd0;
      tok = '0;

      case (mode_ff)
         MODE_SLASH: begin
            if (source_byte == "/") begin
               mode_in = MODE_COMMENT;
               done = 1'b1;
            end else begin
               tok[cnt] = mk(K_SLASH, start_ff, len_p, line_ff);
               cnt = cnt + 2'd1;
            end
         end
         MODE_COMMENT: begin
            done = source_byte != "\n" && source_byte != 8'd0;
         end
         MODE_IDENT: begin
            if (is_alpha(source_byte) || is_digit(source_byte)) begin
               if (len_p < OFF_W'(6))
                  prefix_in[8*len_p[2:0] +: 8] = source_byte;
               done = 1'b1;
            end else begin
               tok[cnt] = mk(ident_kind(prefix_ff, len_p), start_ff, len_p, line_ff);
               cnt = cnt + 2'd1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(source_byte)) begin
               done = 1'b1;
            end else if (source_byte == ".") begin
               mode_in = MODE_NUMDOT;
               done = 1'b1;
            end else begin
               tok[cnt] = mk(K_NUMBER, start_ff, len_p, line_ff);
               cnt = cnt + 2'd1;
            end
         end
         MODE_NUMDOT: begin
            if (is_digit(source_byte)) begin
               mode_in = MODE_FRACTION;
               done = 1'b1;
            end else begin
               // number without the dot, then the dot on its own
               tok[0] = mk(K_NUMBER, start_ff,
                           (len_p != '0) ? len_p - OFF_W'(1) : '0, line_ff);
               tok[1] = mk(K_DOT, (read_ff != '0) ? read_ff - OFF_W'(1) : '0,
                           OFF_W'(1), line_ff);
               cnt = 2'd2;
            end
         end
         MODE_FRACTION: begin
            if (is_digit(source_byte)) begin
               done = 1'b1;
            end else begin
               tok[cnt] = mk(K_NUMBER, start_ff, len_p, line_ff);
               cnt = cnt + 2'd1;
            end
         end
         MODE_STRING: begin
            if (source_byte == "\"") begin
               tok[cnt] = mk(K_STRING, start_ff, len_inc, line_ff);
               cnt = cnt + 2'd1;
               mode_in = MODE_IDLE;
               done = 1'b1;
            end else if (source_byte == "\n") begin
               line_in = line_up;
               done = 1'b1;
            end else if (source_byte == 8'd0) begin
               tok[cnt] = mk(K_ERR_STRING, start_ff, len_p, line_ff);
               cnt = cnt + 2'd1;
            end else begin
               done = 1'b1;
            end
         end
         MODE_OPERATOR: begin
            if (source_byte == "=") begin
               tok[cnt] = mk(op_kind + 6'd1, start_ff, len_inc, line_ff);
               cnt = cnt + 2'd1;
               mode_in = MODE_IDLE;
               done = 1'b1;
            end else begin
               tok[cnt] = mk(op_kind, start_ff, len_p, line_ff);
               cnt = cnt + 2'd1;
            end
         end
         default: ;
      endcase

      if (!done) begin
         mode_in = MODE_IDLE;
         start_in = read_ff;
         case (source_byte)
            " ", "\r", "\t": ;
            "\n": line_in = line_up;
            "/": mode_in = MODE_SLASH;
            "\"": mode_in = MODE_STRING;
            "!": begin pend_in = OP_BANG;    mode_in = MODE_OPERATOR; end
            "=": begin pend_in = OP_EQUAL;   mode_in = MODE_OPERATOR; end
            ">": begin pend_in = OP_GREATER; mode_in = MODE_OPERATOR; end
            "<": begin pend_in = OP_LESS;    mode_in = MODE_OPERATOR; end
            "(": begin tok[cnt] = mk(K_LPAREN, read_ff, OFF_W'(1), line_ff); cnt++; end
            ")": begin tok[cnt] = mk(K_RPAREN, read_ff, OFF_W'(1), line_ff); cnt++; end
            "{": begin tok[cnt] = mk(K_LBRACE, read_ff, OFF_W'(1), line_ff); cnt++; end
            "}": begin tok[cnt] = mk(K_RBRACE, read_ff, OFF_W'(1), line_ff); cnt++; end
            "[": begin tok[cnt] = mk(K_LBRACKET, read_ff, OFF_W'(1), line_ff); cnt++; end
            "]": begin tok[cnt] = mk(K_RBRACKET, read_ff, OFF_W'(1), line_ff); cnt++; end
            ";": begin tok[cnt] = mk(K_SEMICOLON, read_ff, OFF_W'(1), line_ff); cnt++; end
            ",": begin tok[cnt] = mk(K_COMMA, read_ff, OFF_W'(1), line_ff); cnt++; end
            ".": begin tok[cnt] = mk(K_DOT, read_ff, OFF_W'(1), line_ff); cnt++; end
            "-": begin tok[cnt] = mk(K_MINUS, read_ff, OFF_W'(1), line_ff); cnt++; end
            "+": begin tok[cnt] = mk(K_PLUS, read_ff, OFF_W'(1), line_ff); cnt++; end
            "*": begin tok[cnt] = mk(K_STAR, read_ff, OFF_W'(1), line_ff); cnt++; end
            8'd0: begin
               // end of source: report, then rewind for the next source
               tok[cnt] = mk(K_EOF, read_ff, '0, line_ff);
               cnt = cnt + 2'd1;
               start_in = '0;
               read_in = '0;
               line_in = LINE_W'(1);
               prefix_in = '0;
               pend_in = OP_BANG;
            end
            default: begin
               if (is_alpha(source_byte)) begin
                  mode_in = MODE_IDENT;
                  prefix_in = {40'd0, source_byte};
               end else if (is_digit(source_byte)) begin
                  mode_in = MODE_NUMBER;
               end else begin
                  tok[cnt] = mk(K_ERR_CHAR, read_ff, OFF_W'(1), line_ff);
                  cnt = cnt + 2'd1;
               end
            end
         endcase
      end

      if (source_byte != 8'd0)
         read_in = p_inc;
   end

   assign bundle.tok = tok;
   assign bundle.count = cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= OP_BANG;
         start_ff <= '0;
         read_ff <= '0;
         line_ff <= LINE_W'(1);
         prefix_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         start_ff <= start_in;
         read_ff <= read_in;
         line_ff <= line_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/stc_out_buf.sv -----
// ----------------------------------------------------------------------------
// stc_out_buf
// Holds the tokens of one source byte and hands them out one per ready cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stc_out_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire stc_pkg::tok_bundle_type  bundle,
   output logic                          can_load,
   stc_rsp_if.source                     rsp
);
   import stc_pkg::*;

   token_type [MAX_TOKENS-1:0] tok_ff;
   logic [1:0]                 count_ff;
   logic [1:0]                 head_ff;
   logic                       rsp_fire;
   logic                       last;

   assign last = (head_ff + 2'd1) == count_ff;
   assign rsp.valid = head_ff != count_ff;
   assign rsp_fire = rsp.valid && rsp.ready;
   // free when empty, or when the final token leaves this cycle
   assign can_load = !rsp.valid || (rsp_fire && last);

   assign rsp.token_kind = tok_ff[head_ff].kind;
   assign rsp.token_offset = tok_ff[head_ff].offset;
   assign rsp.token_length = tok_ff[head_ff].length;
   assign rsp.token_line = tok_ff[head_ff].line;
   assign rsp.last_in_run = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff <= 2'd0;
      end else if (load) begin
         count_ff <= bundle.count;
         head_ff <= 2'd0;
      end else if (rsp_fire) begin
         head_ff <= head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         tok_ff <= bundle.tok;
   end

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= count_ff) else $error("token head beyond count");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (head_ff == count_ff) || (rsp_fire && last))
      else $error("request taken over pending tokens");
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !last |=> rsp.valid) else $error("token run broken");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(MAX_TOKENS)) else $error("token count too large");

endmodule
`default_nettype wire

// ----- hw/rtl/script_token_scanner.sv -----
// ----------------------------------------------------------------------------
// script_token_scanner
// Byte-serial lexer emitting tokens as kind, offset, length and line.
// ----------------------------------------------------------------------------
// At most one source byte is taken per cycle; a byte that completes tokens
// yields one to three, delivered from an output buffer one per ready cycle,
// with last_in_run marking the final token of that byte. A new byte is taken
// in the same cycle that the buffer's last token leaves, so bytes yielding at
// most one token each run at one byte per clock with a ready receiver. Byte 0
// ends the source, emits the end token and rewinds offset and line count.
`timescale 1ns / 1ps
`default_nettype none
module script_token_scanner (
   input  wire logic  clock,
   input  wire logic  reset,
   stc_req_if.sink    req_ch,
   stc_rsp_if.source  rsp_ch
);
   import stc_pkg::*;

   tok_bundle_type bundle;
   logic           can_load;
   logic           req_fire;

   assign req_ch.ready = can_load;
   assign req_fire = req_ch.valid && can_load;

   stc_step u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_fire),
      .source_byte (req_ch.source_byte),
      .bundle      (bundle)
   );

   stc_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .bundle   (bundle),
      .can_load (can_load),
      .rsp      (rsp_ch)
   );

endmodule
`default_nettype wire
